@@ rtl/core/cle_pkg.sv @@
// Shared types and constants for the console line editor.
// Holds the result kind codes and the control key codes; no dependencies.

package cle_pkg;

	// Result kinds carried on the output channel
	typedef enum logic [2:0] {
		K_NONE  = 3'd0,
		K_ECHO  = 3'd1,
		K_ERASE = 3'd2,
		K_DATA  = 3'd3,
		K_EOF   = 3'd4,
		K_EMPTY = 3'd5
	} kind_t;

	// Control keys
	localparam logic [7:0] KEY_NUL  = 8'h00;
	localparam logic [7:0] KEY_EOF  = 8'h04;
	localparam logic [7:0] KEY_BS   = 8'h08;
	localparam logic [7:0] KEY_LF   = 8'h0A;
	localparam logic [7:0] KEY_CR   = 8'h0D;
	localparam logic [7:0] KEY_DUMP = 8'h10;
	localparam logic [7:0] KEY_KILL = 8'h15;
	localparam logic [7:0] KEY_DEL  = 8'h7F;

	// Default ring depth in bytes
	localparam int BUF_DEPTH_DEF = 128;

endpackage

@@ rtl/core/console_line_editor_top.sv @@
// Console line editor: canonical line discipline over a byte ring.
// Depends on cle_pkg for kind codes and key codes.
//
// Usage:
//   The input channel (in_valid / in_stall) carries one beat per key byte
//   (command 0) or per byte pulled by the reader (command 1). The output
//   channel (out_valid / out_stall) returns exactly one result beat for each
//   input beat, in order: echo, erase echo, data byte, end of file, empty or none.
//   A beat is accepted into the input register; once the result register is
//   free, a pass computes its result from the ring pointers and the registered
//   ring read and loads the result register. Throughput is one beat per cycle
//   while the receiver does not stall: the pointer update, the ring write and
//   the read of the next reader slot all complete in that single pass, with
//   a bypass when the slot written is the slot read next.
//   When the receiver stalls, the result register holds, the input register
//   holds its beat, and in_stall rises so no further beat enters until the
//   result drains.
//   Reset clears the three pointers and both valid flags; the ring itself
//   keeps its contents, and only committed (written) slots are ever read.
//   There is no clearing pass: the block takes beats from the first cycle.

module console_line_editor_top
	import cle_pkg::*;
#(
	parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       command,
	input  logic [7:0] key_code,
	input  logic       first_of_read,
	output logic       out_valid,
	input  logic       out_stall,
	output kind_t      kind,
	output logic [7:0] data_byte,
	output logic [7:0] erase_count,
	output logic       line_committed,
	output logic       end_of_line
);

	localparam int ADDR_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	localparam int PTR_W  = $clog2(2 * BUF_DEPTH);
	localparam int WIDE_W = (PTR_W > 8) ? PTR_W : 8;

	typedef logic [PTR_W-1:0]  ptr_t;
	typedef logic [ADDR_W-1:0] addr_t;

	localparam ptr_t PTR_LAST = PTR_W'(2 * BUF_DEPTH - 1);
	localparam ptr_t PTR_SPAN = PTR_W'(2 * BUF_DEPTH);
	localparam ptr_t DEPTH_P  = PTR_W'(BUF_DEPTH);

	function automatic ptr_t ptr_inc(input ptr_t p);
		return (p == PTR_LAST) ? '0 : ptr_t'(p + ptr_t'(1));
	endfunction

	function automatic ptr_t ptr_dec(input ptr_t p);
		return (p == '0) ? PTR_LAST : ptr_t'(p - ptr_t'(1));
	endfunction

	function automatic ptr_t ptr_dist(input ptr_t hi, input ptr_t lo);
		return ptr_t'(hi - lo + ((hi < lo) ? PTR_SPAN : '0));
	endfunction

	function automatic addr_t ptr_slot(input ptr_t p);
		ptr_t s;
		s = (p >= DEPTH_P) ? ptr_t'(p - DEPTH_P) : p;
		return s[ADDR_W-1:0];
	endfunction

	// Input register
	logic       valid_s1;
	logic       command_s1;
	logic [7:0] key_s1;
	logic       first_s1;

	// Ring pointers
	ptr_t read_ptr_q, commit_ptr_q, edit_ptr_q;
	ptr_t read_ptr_d, commit_ptr_d, edit_ptr_d;

	// Ring storage and its registered read port
	logic [7:0] line_store [BUF_DEPTH];
	logic [7:0] rd_raw_q;
	logic       byp_q;
	logic [7:0] byp_data_q;
	logic [7:0] rd_data;
	addr_t      rd_addr;
	addr_t      wr_addr;
	logic       wr_en;
	logic [7:0] wr_data;

	// Result register
	logic       out_valid_q;
	kind_t      kind_q, kind_d;
	logic [7:0] data_q, data_d;
	logic [7:0] erase_q, erase_d;
	logic       commit_q, commit_d;
	logic       eol_q, eol_d;

	logic advance;
	ptr_t kill_n;
	logic [WIDE_W-1:0] kill_n_wide;
	ptr_t edit_inc;
	logic [7:0] key_mapped;

	// Handshake: the single pass fires when the result register is free
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// Capture input beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			command_s1 <= command;
			key_s1     <= key_code;
			first_s1   <= first_of_read;
		end
	end

	// Read data with bypass of a write to the same slot on the same edge
	assign rd_data = byp_q ? byp_data_q : rd_raw_q;

	assign kill_n      = ptr_dist(edit_ptr_q, commit_ptr_q);
	assign kill_n_wide = WIDE_W'(kill_n);
	assign edit_inc    = ptr_inc(edit_ptr_q);
	assign key_mapped  = (key_s1 == KEY_CR) ? KEY_LF : key_s1;

	// Single pass: decode the beat, move pointers, form the result
	always_comb begin
		read_ptr_d   = read_ptr_q;
		commit_ptr_d = commit_ptr_q;
		edit_ptr_d   = edit_ptr_q;
		wr_en        = 1'b0;
		wr_addr      = ptr_slot(edit_ptr_q);
		wr_data      = key_mapped;
		kind_d       = K_NONE;
		data_d       = 8'h00;
		erase_d      = 8'h00;
		commit_d     = 1'b0;
		eol_d        = 1'b0;
		if (advance) begin
			if (command_s1) begin
				priority if (read_ptr_q == commit_ptr_q) begin
					kind_d = K_EMPTY;
				end else if (rd_data == KEY_EOF) begin
					kind_d = K_EOF;
					if (first_s1) begin
						read_ptr_d = ptr_inc(read_ptr_q);
					end
				end else begin
					kind_d     = K_DATA;
					data_d     = rd_data;
					eol_d      = (rd_data == KEY_LF);
					read_ptr_d = ptr_inc(read_ptr_q);
				end
			end else begin
				priority if (key_s1 == KEY_DUMP || key_s1 == KEY_NUL) begin
					kind_d = K_NONE;
				end else if (key_s1 == KEY_KILL) begin
					edit_ptr_d = commit_ptr_q;
					if (kill_n != '0) begin
						kind_d  = K_ERASE;
						erase_d = (kill_n_wide > WIDE_W'(255)) ? 8'hFF : kill_n_wide[7:0];
					end
				end else if (key_s1 == KEY_BS || key_s1 == KEY_DEL) begin
					if (edit_ptr_q != commit_ptr_q) begin
						edit_ptr_d = ptr_dec(edit_ptr_q);
						kind_d     = K_ERASE;
						erase_d    = 8'd1;
					end
				end else if (ptr_dist(edit_ptr_q, read_ptr_q) < DEPTH_P) begin
					wr_en      = 1'b1;
					edit_ptr_d = edit_inc;
					kind_d     = K_ECHO;
					data_d     = key_mapped;
					if (key_mapped == KEY_LF || key_mapped == KEY_EOF ||
					    ptr_dist(edit_inc, read_ptr_q) == DEPTH_P) begin
						commit_ptr_d = edit_inc;
						commit_d     = 1'b1;
					end
				end else begin
					kind_d = K_NONE;
				end
			end
		end
	end

	// Prefetch the slot the reader takes next
	assign rd_addr = ptr_slot(read_ptr_d);

	// Ring write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			line_store[wr_addr] <= wr_data;
		end
		rd_raw_q   <= line_store[rd_addr];
		byp_q      <= wr_en && (wr_addr == rd_addr);
		byp_data_q <= wr_data;
	end

	// Advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_ptr_q   <= '0;
			commit_ptr_q <= '0;
			edit_ptr_q   <= '0;
		end else begin
			read_ptr_q   <= read_ptr_d;
			commit_ptr_q <= commit_ptr_d;
			edit_ptr_q   <= edit_ptr_d;
		end
	end

	// Result valid: load on a pass, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (advance) begin
			kind_q   <= kind_d;
			data_q   <= data_d;
			erase_q  <= erase_d;
			commit_q <= commit_d;
			eol_q    <= eol_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign data_byte      = data_q;
	assign erase_count    = erase_q;
	assign line_committed = commit_q;
	assign end_of_line    = eol_q;

	// Pointer ordering: read <= commit <= edit <= read + depth
	ptr_t dist_cr, dist_er;
	assign dist_cr = ptr_dist(commit_ptr_q, read_ptr_q);
	assign dist_er = ptr_dist(edit_ptr_q, read_ptr_q);

	a_ptr_order: assert property (@(posedge clk) disable iff (!arst_n)
		dist_cr <= dist_er && dist_er <= DEPTH_P)
		else $error("ring pointers out of order");

	a_commit_catches_edit: assert property (@(posedge clk) disable iff (!arst_n)
		advance && commit_d |=> commit_ptr_q == edit_ptr_q)
		else $error("commit did not reach edit pointer");

	a_erase_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == K_ERASE |-> erase_q != 8'h00)
		else $error("erase result with zero count");

	a_eol_is_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && eol_q |-> kind_q == K_DATA && data_q == KEY_LF)
		else $error("end of line flag on a non-newline result");

	a_commit_on_echo: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && commit_q |-> kind_q == K_ECHO)
		else $error("commit flag outside a stored key");

endmodule
